>>> rtl/bedc_pkg.sv
package bedc_pkg;

  localparam int TIME_BITS = 32;
  localparam int INTERVAL_BITS = 16;
  localparam int CMP_BITS = (TIME_BITS > INTERVAL_BITS) ? TIME_BITS : INTERVAL_BITS;
  localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = INTERVAL_BITS'(500);

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_DOWN   = 3'd1,
    EV_UP     = 3'd2,
    EV_HELD   = 3'd3,
    EV_DOUBLE = 3'd4
  } btn_ev_t;

  typedef struct packed {
    logic        left_level;
    logic        right_level;
    logic        middle_level;
    logic [31:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] left_event;
    logic [2:0] right_event;
    logic [2:0] middle_event;
  } out_beat_t;

  // shared by all lanes for one tick
  typedef struct packed {
    logic                     take;
    logic [TIME_BITS-1:0]     now;
    logic [INTERVAL_BITS-1:0] interval;
  } lane_ctl_t;

endpackage

>>> rtl/bedc_lane.sv
module bedc_lane (
  input  logic                clk,
  input  logic                rst,
  input  bedc_pkg::lane_ctl_t ctl,
  input  logic                level,
  output bedc_pkg::btn_ev_t   ev
);
  import bedc_pkg::*;

  logic                 prev;
  logic [1:0]           cnt;
  logic [TIME_BITS-1:0] first_time;
  logic [1:0]           cnt_next;
  logic [TIME_BITS-1:0] first_time_next;

  logic [TIME_BITS-1:0] elapsed;
  logic [CMP_BITS-1:0]  elapsed_w;
  logic [CMP_BITS-1:0]  interval_w;
  logic                 ge;
  logic                 le;
  logic [1:0]           cnt_eff;

  assign elapsed    = ctl.now - first_time;
  assign elapsed_w  = CMP_BITS'(elapsed);
  assign interval_w = CMP_BITS'(ctl.interval);
  assign ge         = elapsed_w >= interval_w;
  assign le         = elapsed_w <= interval_w;
  // a stale first press is dropped before counting a new one
  assign cnt_eff    = (cnt == 2'd1 && ge) ? 2'd0 : cnt;

  always_comb begin
    ev              = EV_NONE;
    cnt_next        = cnt;
    first_time_next = first_time;
    if (!prev && level) begin
      ev = EV_DOWN;
      cnt_next = (cnt_eff == 2'd3) ? 2'd3 : cnt_eff + 2'd1;
      if (cnt_next == 2'd1) begin
        first_time_next = ctl.now;
      end
    end else if (prev && !level) begin
      ev = EV_UP;
      if (cnt == 2'd1) begin
        if (ge) begin
          cnt_next = 2'd0;
        end
      end else if (cnt == 2'd2) begin
        if (le) begin
          ev = EV_DOUBLE;
        end
        cnt_next = 2'd0;
      end
    end else if (prev && level) begin
      ev = EV_HELD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev       <= 1'b0;
      cnt        <= 2'd0;
      first_time <= '0;
    end else if (ctl.take) begin
      prev       <= level;
      cnt        <= cnt_next;
      first_time <= first_time_next;
    end
  end

  a_cnt_never_three: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("click count reached three");
  a_double_needs_two: assert property (@(posedge clk) disable iff (rst)
    ev == EV_DOUBLE |-> cnt == 2'd2)
    else $error("double click without two counted presses");
  a_double_clears: assert property (@(posedge clk) disable iff (rst)
    (ctl.take && ev == EV_DOUBLE) |=> cnt == 2'd0)
    else $error("count not cleared after double click");
  a_first_press_time: assert property (@(posedge clk) disable iff (rst)
    (ctl.take && ev == EV_DOWN && cnt_next == 2'd1) |=> first_time == $past(ctl.now))
    else $error("first press time not captured");

endmodule

>>> rtl/bedc_merge.sv
module bedc_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  bedc_pkg::btn_ev_t   left_ev,
  input  bedc_pkg::btn_ev_t   right_ev,
  input  bedc_pkg::btn_ev_t   middle_ev,
  output logic                hold,
  output logic                out_valid,
  input  logic                out_stall,
  output bedc_pkg::out_beat_t out_data
);
  import bedc_pkg::*;

  assign hold = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (take) begin
      out_data.left_event   <= 3'(left_ev);
      out_data.right_event  <= 3'(right_ev);
      out_data.middle_event <= 3'(middle_ev);
    end
  end

  a_take_fills: assert property (@(posedge clk) disable iff (rst) take |=> out_valid)
    else $error("accepted tick did not produce a beat");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst) hold |-> !take)
    else $error("held beat overwritten");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !take) |=> !out_valid)
    else $error("beat repeated after delivery");

endmodule

>>> rtl/button_edge_and_double_click_unit.sv
// Button edge and double-click detector for left, right and middle buttons.
// One tick is accepted every clock cycle and its three events appear on the
// output in the cycle after acceptance, held in a single output register; the
// input stalls only while that register holds a beat that is itself stalled.
// Each button has its own lane with one timestamp subtract and interval
// compares, so the lanes run side by side. The double-click interval resets
// to 500 ms and is written through cfg_we and cfg_data; the user must write
// it only while no tick is in flight, as the block does not enforce this.
module button_edge_and_double_click_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bedc_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bedc_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data
);
  import bedc_pkg::*;

  logic [INTERVAL_BITS-1:0] interval;
  lane_ctl_t                ctl;
  logic                     hold;
  btn_ev_t                  left_ev;
  btn_ev_t                  right_ev;
  btn_ev_t                  middle_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
    end else if (cfg_we) begin
      interval <= cfg_data;
    end
  end

  assign in_stall     = hold;
  assign ctl.take     = in_valid && !hold;
  assign ctl.now      = TIME_BITS'(in_data.now_ms);
  assign ctl.interval = interval;

  bedc_lane u_left (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .level (in_data.left_level),
    .ev    (left_ev)
  );

  bedc_lane u_right (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .level (in_data.right_level),
    .ev    (right_ev)
  );

  bedc_lane u_middle (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .level (in_data.middle_level),
    .ev    (middle_ev)
  );

  bedc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .take      (ctl.take),
    .left_ev   (left_ev),
    .right_ev  (right_ev),
    .middle_ev (middle_ev),
    .hold      (hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat present after reset");
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> interval == $past(cfg_data))
    else $error("interval write lost");

endmodule
